// ----- rtl/core/zbmp_pkg.sv -----
// Shared constants for the zero-byte mask packer.
package zbmp_pkg;

    localparam int GROUP_SIZE       = 8;
    localparam int GROUP_IDX_W      = $clog2(GROUP_SIZE);
    localparam int GROUP_CNT_W      = $clog2(GROUP_SIZE + 1);
    localparam int BYTE_W           = 8;
    localparam int LIMIT_W          = 11;
    localparam int OUT_CAPACITY_DEF = 1024;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

endpackage

// ----- rtl/core/zero_byte_mask_packer.sv -----
// Zero-byte mask packer: groups of up to eight bytes become a mask byte plus the nonzero bytes.
// Input bytes are accepted while idle and the output register is free; the mask byte is
// registered in the cycle that accepts a group's closing byte and appears in the next cycle.
// The group's k buffered nonzero bytes then leave one per cycle while the output is not
// stalled, from the eight-entry group buffer, and input is stalled meanwhile.
// Synchronous active-low reset clears all counters and sets the output limit to 1024.
module zero_byte_mask_packer #(
    parameter int OUT_CAPACITY = zbmp_pkg::OUT_CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [zbmp_pkg::LIMIT_W-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [zbmp_pkg::BYTE_W-1:0]      i_in_byte,
    input  logic                             i_in_last,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [zbmp_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                             o_is_mask,
    output logic                             o_out_last,
    output logic                             o_overflow_error
);

    localparam int LimW = zbmp_pkg::LIMIT_W;
    localparam int CapW = $clog2(OUT_CAPACITY + 1);
    localparam int CmpW = (LimW > CapW) ? LimW : CapW;
    localparam int IdxW = zbmp_pkg::GROUP_IDX_W;
    localparam int CntW = zbmp_pkg::GROUP_CNT_W;
    localparam int ByteW = zbmp_pkg::BYTE_W;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [LimW-1:0]         r_limit;
    logic [ByteW-1:0]        r_store [zbmp_pkg::GROUP_SIZE];
    logic [IdxW-1:0]         r_fill;
    logic [ByteW-1:0]        r_mask;
    logic [CntW-1:0]         r_nz;
    logic [LimW-1:0]         r_count;
    logic                    r_disc;
    logic [IdxW-1:0]         r_idx;
    logic                    r_pkt_last;
    logic                    r_ovalid;
    logic [ByteW-1:0]        r_obyte;
    logic                    r_omask;
    logic                    r_olast;
    logic                    r_oerr;

    logic [LimW-1:0]         eff_limit;
    logic                    out_free;
    logic                    in_acc;
    logic                    first_byte;
    logic                    byte_nz;
    logic [LimW:0]           need_count;
    logic                    err_hit;
    logic [ByteW-1:0]        n_mask;
    logic [CntW-1:0]         n_nz;
    logic                    grp_done;
    logic                    emit_final;
    logic                    out_load;

    // Limit above the build capacity acts as the capacity.
    assign eff_limit = (CmpW'(r_limit) > CmpW'(OUT_CAPACITY)) ? LimW'(OUT_CAPACITY) : r_limit;

    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign first_byte = (r_fill == '0);
    assign byte_nz    = (i_in_byte != '0);

    // The first byte of a group reserves the mask slot before its own data slot.
    assign need_count = {1'b0, r_count} + (LimW + 1)'(first_byte);
    assign err_hit    = (first_byte && (r_count >= eff_limit)) ||
                        (byte_nz && (need_count >= {1'b0, eff_limit}));

    assign n_mask   = byte_nz ? (r_mask | (ByteW'(1) << r_fill)) : r_mask;
    assign n_nz     = byte_nz ? (r_nz + CntW'(1)) : r_nz;
    assign grp_done = (r_fill == IdxW'(zbmp_pkg::GROUP_SIZE - 1)) || i_in_last;

    assign emit_final = ({1'b0, r_idx} == (r_nz - CntW'(1)));

    // A new result enters the output register in this cycle.
    assign out_load = (in_acc && !r_disc && (err_hit || grp_done)) ||
                      ((r_state == S_EMIT) && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_limit    <= zbmp_pkg::LIMIT_RESET;
            r_fill     <= '0;
            r_mask     <= '0;
            r_nz       <= '0;
            r_count    <= '0;
            r_disc     <= 1'b0;
            r_idx      <= '0;
            r_pkt_last <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (r_ovalid && !i_out_stall && !out_load) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        priority if (r_disc) begin
                            if (i_in_last) begin
                                r_disc  <= 1'b0;
                                r_count <= '0;
                            end
                        end else if (err_hit) begin
                            r_ovalid <= 1'b1;
                            r_obyte  <= '0;
                            r_omask  <= 1'b0;
                            r_olast  <= 1'b1;
                            r_oerr   <= 1'b1;
                            r_fill   <= '0;
                            r_mask   <= '0;
                            r_nz     <= '0;
                            if (i_in_last) begin
                                r_count <= '0;
                            end else begin
                                r_disc <= 1'b1;
                            end
                        end else begin
                            if (byte_nz) begin
                                r_store[r_nz[IdxW-1:0]] <= i_in_byte;
                            end
                            r_nz <= n_nz;
                            if (grp_done) begin
                                r_ovalid   <= 1'b1;
                                r_obyte    <= n_mask;
                                r_omask    <= 1'b1;
                                r_olast    <= i_in_last && (n_nz == '0);
                                r_oerr     <= 1'b0;
                                r_fill     <= '0;
                                r_mask     <= '0;
                                r_idx      <= '0;
                                r_pkt_last <= i_in_last;
                                if (i_in_last) begin
                                    r_count <= '0;
                                end else begin
                                    r_count <= need_count[LimW-1:0] + LimW'(byte_nz);
                                end
                                if (n_nz != '0) begin
                                    r_state <= S_EMIT;
                                end
                            end else begin
                                r_fill  <= r_fill + IdxW'(1);
                                r_mask  <= n_mask;
                                r_count <= need_count[LimW-1:0] + LimW'(byte_nz);
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_obyte  <= r_store[r_idx];
                        r_omask  <= 1'b0;
                        r_olast  <= r_pkt_last && emit_final;
                        r_oerr   <= 1'b0;
                        if (emit_final) begin
                            r_nz    <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + IdxW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_out_byte       = r_obyte;
    assign o_is_mask        = r_omask;
    assign o_out_last       = r_olast;
    assign o_overflow_error = r_oerr;

    // The emit sequence only runs when bytes are buffered.
    a_emit_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_nz != '0))
        else $error("emit state with empty group buffer");

    // While dropping a packet, no group is being assembled.
    a_disc_no_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> ((r_state == S_IDLE) && (r_fill == '0) && (r_nz == '0)))
        else $error("group state while discarding");

    // Outside the emit sequence, buffered bytes never outnumber taken bytes.
    a_nz_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ({1'b0, r_fill} >= r_nz))
        else $error("buffered count exceeds group fill");

    // An overflow result always closes the packet and is never a mask.
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow_error) |-> (o_out_last && !o_is_mask))
        else $error("malformed overflow result");

    // A new result is only loaded once the previous one has been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> r_ovalid)
        else $error("pending result dropped");

endmodule
